// ===== hw/rtl/ft8qs_pkg.sv =====
// Shared types and constants for the FT8 contact sequencer.
`timescale 1ns / 1ps

package ft8qs_pkg;

  // Retry cap loaded on phases that repeat their message
  localparam logic [2:0] MaxRetries = 3'd5;

  // Operation codes carried in tuser
  localparam logic [2:0] OP_START_CQ    = 3'd0;
  localparam logic [2:0] OP_START_REPLY = 3'd1;
  localparam logic [2:0] OP_DECODE      = 3'd2;
  localparam logic [2:0] OP_FETCH       = 3'd3;
  localparam logic [2:0] OP_TICK        = 3'd4;

  // Message kinds
  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_GRID    = 3'd1,
    KIND_REPORT  = 3'd2,
    KIND_RREPORT = 3'd3,
    KIND_RR73    = 3'd4,
    KIND_73      = 3'd5,
    KIND_CQ      = 3'd6
  } kind_e;

  // Contact phase, one-hot
  typedef enum logic [6:0] {
    PH_IDLE         = 7'b0000001,
    PH_REPLYING     = 7'b0000010,
    PH_REPORT       = 7'b0000100,
    PH_ROGER_REPORT = 7'b0001000,
    PH_ROGERS       = 7'b0010000,
    PH_SIGNOFF      = 7'b0100000,
    PH_CALLING      = 7'b1000000
  } phase_e;

  // Output codes for the phase
  localparam logic [2:0] PHC_IDLE         = 3'd0;
  localparam logic [2:0] PHC_REPLYING     = 3'd1;
  localparam logic [2:0] PHC_REPORT       = 3'd2;
  localparam logic [2:0] PHC_ROGER_REPORT = 3'd3;
  localparam logic [2:0] PHC_ROGERS       = 3'd4;
  localparam logic [2:0] PHC_SIGNOFF      = 3'd5;
  localparam logic [2:0] PHC_CALLING      = 3'd6;

  // Sequencer state
  typedef struct packed {
    phase_e             phase;
    kind_e              pending;
    logic [2:0]         retry_count;
    logic [2:0]         retry_cap;
    logic [27:0]        partner;
    logic signed [6:0]  rpt_send;
    logic signed [6:0]  rpt_heard;
    logic               logged;
  } state_t;

  // One input item
  typedef struct packed {
    logic [2:0]         op;
    logic [27:0]        to_call;
    logic [27:0]        from_call;
    logic signed [6:0]  heard_snr;
    logic signed [6:0]  their_report;
    logic               is_grid;
    logic [31:0]        third_field;
  } item_t;

  // One result item
  typedef struct packed {
    logic               tx_wanted;
    kind_e              tx_kind;
    logic [27:0]        partner_call;
    logic signed [6:0]  sent_report;
    logic signed [6:0]  partner_report;
    logic               log_request;
    logic [2:0]         phase_now;
  } result_t;

endpackage

// ===== hw/rtl/ft8qs_step.sv =====
// Next-state and result logic for one sequencer item.
`timescale 1ns / 1ps

module ft8qs_step (
  input  ft8qs_pkg::state_t  state_i,
  input  logic [27:0]        my_call_i,
  input  ft8qs_pkg::item_t   item_i,
  output ft8qs_pkg::state_t  state_o,
  output ft8qs_pkg::result_t result_o
);
  import ft8qs_pkg::*;

  // Third-field text patterns
  localparam logic [15:0] Txt73   = 16'h3733;
  localparam logic [31:0] TxtRr73 = 32'h52523733;
  localparam logic [23:0] TxtRrr  = 24'h525252;
  localparam logic [7:0]  TxtR    = 8'h52;

  function automatic kind_e classify(input logic grid, input logic [31:0] text);
    kind_e k;
    if (grid)                    k = KIND_GRID;
    else if (text[31:16] == Txt73) k = KIND_73;
    else if (text == TxtRr73)    k = KIND_RR73;
    else if (text[31:8] == TxtRrr) k = KIND_RR73;
    else if (text[31:24] == TxtR) k = KIND_RREPORT;
    else                         k = KIND_REPORT;
    return k;
  endfunction

  function automatic state_t enter(input state_t s, input phase_e ph, input kind_e k,
                                   input logic [2:0] cap);
    state_t r;
    r             = s;
    r.phase       = ph;
    r.pending     = k;
    r.retry_count = 3'd0;
    r.retry_cap   = cap;
    return r;
  endfunction

  kind_e  kind;
  kind_e  again;
  logic   gated;
  logic   addr_ok;
  logic   is_end;
  state_t nx;

  assign kind   = classify(item_i.is_grid, item_i.third_field);
  assign gated  = (state_i.phase == PH_REPLYING) || (state_i.phase == PH_REPORT) ||
                  (state_i.phase == PH_ROGER_REPORT);
  assign addr_ok = (item_i.to_call == my_call_i) &&
                   !(gated && (item_i.from_call != state_i.partner));
  assign is_end = (kind == KIND_RR73) || (kind == KIND_73);

  // Message to repeat on a tick, per phase
  always_comb begin
    case (state_i.phase)
      PH_REPLYING:     again = KIND_GRID;
      PH_REPORT:       again = KIND_REPORT;
      PH_ROGER_REPORT: again = KIND_RREPORT;
      PH_ROGERS:       again = KIND_RR73;
      PH_SIGNOFF:      again = KIND_73;
      default:         again = KIND_NONE;
    endcase
  end

  // Main step
  always_comb begin
    nx                 = state_i;
    result_o.tx_wanted = 1'b0;
    result_o.log_request = 1'b0;
    result_o.tx_kind   = KIND_NONE;
    case (item_i.op)
      OP_START_CQ: nx = enter(state_i, PH_CALLING, KIND_CQ, 3'd0);
      OP_START_REPLY: begin
        nx         = state_i;
        nx.partner = item_i.from_call;
        nx         = enter(nx, PH_REPLYING, KIND_GRID, MaxRetries);
      end
      OP_DECODE: begin
        if (addr_ok) begin
          nx.partner  = item_i.from_call;
          nx.rpt_send = item_i.heard_snr;
          if ((kind == KIND_REPORT) || (kind == KIND_RREPORT)) begin
            nx.rpt_heard = item_i.their_report;
          end
          case (state_i.phase)
            PH_CALLING: begin
              if (kind == KIND_GRID) begin
                nx = enter(nx, PH_REPORT, KIND_REPORT, MaxRetries);
                result_o.tx_wanted = 1'b1;
              end else if (kind == KIND_REPORT) begin
                nx = enter(nx, PH_ROGER_REPORT, KIND_RREPORT, MaxRetries);
                result_o.tx_wanted = 1'b1;
              end else if (kind == KIND_RREPORT) begin
                nx = enter(nx, PH_ROGERS, KIND_RR73, MaxRetries);
                result_o.tx_wanted = 1'b1;
              end
            end
            PH_REPLYING: begin
              if (kind == KIND_REPORT) begin
                nx = enter(nx, PH_ROGER_REPORT, KIND_RREPORT, MaxRetries);
                result_o.tx_wanted = 1'b1;
              end else if (kind == KIND_RREPORT) begin
                nx = enter(nx, PH_ROGERS, KIND_RR73, MaxRetries);
                result_o.tx_wanted = 1'b1;
              end else if (is_end) begin
                nx = enter(nx, PH_SIGNOFF, KIND_73, 3'd0);
                result_o.tx_wanted = 1'b1;
              end
            end
            PH_REPORT: begin
              if (kind == KIND_RREPORT) begin
                nx = enter(nx, PH_ROGERS, KIND_RR73, MaxRetries);
                result_o.tx_wanted = 1'b1;
              end else if (is_end) begin
                nx = enter(nx, PH_SIGNOFF, KIND_73, 3'd0);
                result_o.tx_wanted = 1'b1;
              end
            end
            PH_ROGER_REPORT: begin
              if (is_end) begin
                nx = enter(nx, PH_SIGNOFF, KIND_73, 3'd0);
                result_o.tx_wanted = 1'b1;
              end
            end
            PH_ROGERS: begin
              if (is_end) nx = enter(nx, PH_IDLE, KIND_NONE, 3'd0);
            end
            PH_SIGNOFF: begin
              if (kind != KIND_RR73) nx = enter(nx, PH_IDLE, KIND_NONE, 3'd0);
            end
            default: ;
          endcase
        end
      end
      OP_FETCH: begin
        if (state_i.pending != KIND_NONE) begin
          result_o.tx_wanted = 1'b1;
          // log once per contact on the closing messages
          if (((state_i.pending == KIND_RR73) || (state_i.pending == KIND_73)) &&
              !state_i.logged) begin
            result_o.log_request = 1'b1;
            nx.logged = 1'b1;
          end
          if (!((state_i.retry_cap != 3'd0) &&
                (state_i.retry_count < state_i.retry_cap))) begin
            if (state_i.retry_cap != 3'd0) nx.phase = PH_SIGNOFF;
            nx.pending = KIND_NONE;
            nx.logged  = 1'b0;
          end
        end
      end
      OP_TICK: begin
        if ((state_i.pending != KIND_NONE) && (again != KIND_NONE)) begin
          if (state_i.retry_count < state_i.retry_cap) begin
            nx.pending     = again;
            nx.retry_count = state_i.retry_count + 3'd1;
          end else if ((state_i.phase == PH_ROGERS) || (state_i.phase == PH_SIGNOFF)) begin
            nx.phase   = PH_IDLE;
            nx.pending = KIND_NONE;
            nx.logged  = 1'b0;
          end else begin
            nx.phase   = PH_SIGNOFF;
            nx.pending = KIND_73;
          end
        end
      end
      default: ;
    endcase
    // fetch reports the kind handed out, others the kind left pending
    result_o.tx_kind = (item_i.op == OP_FETCH) ? state_i.pending : nx.pending;

    // Result fields taken from the new state
    result_o.partner_call   = nx.partner;
    result_o.sent_report    = nx.rpt_send;
    result_o.partner_report = nx.rpt_heard;
    case (nx.phase)
      PH_IDLE:         result_o.phase_now = PHC_IDLE;
      PH_REPLYING:     result_o.phase_now = PHC_REPLYING;
      PH_REPORT:       result_o.phase_now = PHC_REPORT;
      PH_ROGER_REPORT: result_o.phase_now = PHC_ROGER_REPORT;
      PH_ROGERS:       result_o.phase_now = PHC_ROGERS;
      PH_SIGNOFF:      result_o.phase_now = PHC_SIGNOFF;
      PH_CALLING:      result_o.phase_now = PHC_CALLING;
      default:         result_o.phase_now = PHC_IDLE;
    endcase
  end

  assign state_o = nx;

endmodule

// ===== hw/rtl/ft8_qso_auto_sequencer.sv =====
// FT8 contact sequencer: top level with input and result registers.
// The result is registered: an accepted item passes the input register, then the result
// register, and moves on only when the result register is free or being taken.
// Throughput: one item per cycle while results are taken; one ft8qs_step pass per update.
// While a result waits, one more item is taken into the input register, then input stalls.
// Reset (rst_ni low, asynchronous): phase idle, nothing pending, counters, partner,
// reports, log flag and my_call cleared; both register stages empty.
`timescale 1ns / 1ps

module ft8_qso_auto_sequencer (
  input  logic          clk_i,
  input  logic          rst_ni,
  // configuration: my_call
  input  logic          cfg_we_i,
  input  logic [27:0]   cfg_wdata_i,
  // input items
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // to_call[27:0], from_call[55:28], heard_snr[62:56], their_report[69:63],
  // third_field[101:70], zero pad[103:102]
  input  logic [103:0]  s_axis_tdata,
  // operation[2:0], is_grid_message[3]
  input  logic [3:0]    s_axis_tuser,
  // result items
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // tx_wanted[0], partner_call[28:1], sent_report[35:29], partner_report[42:36],
  // log_request[43], phase_now[46:44], zero pad[47]
  output logic [47:0]   m_axis_tdata,
  // tx_kind[2:0]
  output logic [2:0]    m_axis_tuser
);
  import ft8qs_pkg::*;

  logic        in_valid_q;
  item_t       item_q;
  logic        out_valid_q;
  result_t     res_q;
  state_t      state_q, state_d;
  result_t     res_d;
  logic [27:0] my_call_q;
  logic        advance;
  logic        fire_in;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign fire_in       = s_axis_tvalid && s_axis_tready;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_call_q <= '0;
    end else if (cfg_we_i) begin
      my_call_q <= cfg_wdata_i;
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire_in)      in_valid_q <= 1'b1;
      else if (advance) in_valid_q <= 1'b0;
      if (advance)      out_valid_q <= in_valid_q;
    end
  end

  // Input item register
  always_ff @(posedge clk_i) begin
    if (fire_in) begin
      item_q.op           <= s_axis_tuser[2:0];
      item_q.is_grid      <= s_axis_tuser[3];
      item_q.to_call      <= s_axis_tdata[27:0];
      item_q.from_call    <= s_axis_tdata[55:28];
      item_q.heard_snr    <= s_axis_tdata[62:56];
      item_q.their_report <= s_axis_tdata[69:63];
      item_q.third_field  <= s_axis_tdata[101:70];
    end
  end

  ft8qs_step u_step (
    .state_i  (state_q),
    .my_call_i(my_call_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Sequencer state, updated as the item moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase       <= PH_IDLE;
      state_q.pending     <= KIND_NONE;
      state_q.retry_count <= 3'd0;
      state_q.retry_cap   <= 3'd0;
      state_q.partner     <= '0;
      state_q.rpt_send    <= '0;
      state_q.rpt_heard   <= '0;
      state_q.logged      <= 1'b0;
    end else if (advance && in_valid_q) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.tx_kind;
  assign m_axis_tdata  = {1'b0, res_q.phase_now, res_q.log_request, res_q.partner_report,
                          res_q.sent_report, res_q.partner_call, res_q.tx_wanted};

endmodule

// ===== tb/sv/tb_ft8_qso_auto_sequencer.sv =====
// Self-checking testbench for the FT8 contact sequencer: directed and random stream items.
`timescale 1ns / 1ps

module tb_ft8_qso_auto_sequencer;
  import ft8qs_pkg::*;

  // Unused operation codes, the block must ignore them
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  // Retry cap of phases that send their message once only
  localparam logic [2:0] NO_RETRY = 3'd0;

  // Third-field texts, first char in the high byte
  localparam logic [31:0] TXT_73   = 32'h3733_0000;
  localparam logic [31:0] TXT_RR73 = 32'h5252_3733;
  localparam logic [31:0] TXT_RRR  = 32'h5252_5200;
  localparam logic [31:0] TXT_RPT  = 32'h2D31_3200;
  localparam logic [31:0] TXT_RRPT = 32'h522B_3035;
  localparam logic [31:0] TXT_GRID = 32'h464E_3432;
  localparam logic [15:0] PFX_73   = 16'h3733;
  localparam logic [23:0] PFX_RRR  = 24'h525252;
  localparam logic [7:0]  CH_R     = 8'h52;
  localparam logic [7:0]  CH_MINUS = 8'h2D;
  localparam logic [7:0]  CH_PLUS  = 8'h2B;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASE_ITEMS  = 165;
  localparam int RANDOM_PHASES = 6;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [27:0]   cfg_wdata_i = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [103:0]  s_axis_tdata = '0;
  logic [3:0]    s_axis_tuser = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [47:0]   m_axis_tdata;
  logic [2:0]    m_axis_tuser;

  ft8_qso_auto_sequencer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // Predicted sequencer state
  logic [27:0]       station_call  = '0;
  logic [2:0]        seq_phase     = PHC_IDLE;
  kind_e             seq_pending   = KIND_NONE;
  logic [2:0]        seq_retries   = '0;
  logic [2:0]        seq_cap       = NO_RETRY;
  logic [27:0]       seq_partner   = '0;
  logic signed [6:0] seq_rpt_send  = '0;
  logic signed [6:0] seq_rpt_heard = '0;
  logic              seq_logged    = 1'b0;

  item_t   tx_event_queue[$];
  result_t predicted_status[$];
  item_t   offered;
  result_t status_due;

  int          mismatches = 0;
  int          cycle_count = 0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned hold_left = 0;
  int          holds_asked = 0;
  int          holds_done = 0;
  logic        src_gaps_on = 1'b1;
  logic        sink_gaps_on = 1'b1;

  // ---------------------------------------------------------------- prediction

  function automatic void set_phase(logic [2:0] ph, kind_e kind, logic [2:0] cap);
    seq_phase   = ph;
    seq_pending = kind;
    seq_retries = '0;
    seq_cap     = cap;
  endfunction

  // The grid flag is tested first, then 73, then RR73 and RRR, then a leading R
  function automatic kind_e classify_text(logic grid, logic [31:0] txt);
    if (grid) return KIND_GRID;
    if (txt[31:16] == PFX_73) return KIND_73;
    if (txt == TXT_RR73) return KIND_RR73;
    if (txt[31:8] == PFX_RRR) return KIND_RR73;
    if (txt[31:24] == CH_R) return KIND_RREPORT;
    return KIND_REPORT;
  endfunction

  // Decoded message; returns whether a transmission is wanted
  function automatic logic take_decode(item_t it);
    kind_e cls;
    if (it.to_call != station_call) return 1'b0;
    if ((seq_phase == PHC_REPLYING || seq_phase == PHC_REPORT ||
         seq_phase == PHC_ROGER_REPORT) && it.from_call != seq_partner) return 1'b0;
    seq_partner  = it.from_call;
    seq_rpt_send = it.heard_snr;
    cls = classify_text(it.is_grid, it.third_field);
    if (cls == KIND_REPORT || cls == KIND_RREPORT) seq_rpt_heard = it.their_report;
    case (seq_phase)
      PHC_CALLING: begin
        if (cls == KIND_GRID) begin
          set_phase(PHC_REPORT, KIND_REPORT, MaxRetries);
          return 1'b1;
        end
        if (cls == KIND_REPORT) begin
          set_phase(PHC_ROGER_REPORT, KIND_RREPORT, MaxRetries);
          return 1'b1;
        end
        if (cls == KIND_RREPORT) begin
          set_phase(PHC_ROGERS, KIND_RR73, MaxRetries);
          return 1'b1;
        end
      end
      PHC_REPLYING: begin
        if (cls == KIND_REPORT) begin
          set_phase(PHC_ROGER_REPORT, KIND_RREPORT, MaxRetries);
          return 1'b1;
        end
        if (cls == KIND_RREPORT) begin
          set_phase(PHC_ROGERS, KIND_RR73, MaxRetries);
          return 1'b1;
        end
        if (cls == KIND_RR73 || cls == KIND_73) begin
          set_phase(PHC_SIGNOFF, KIND_73, NO_RETRY);
          return 1'b1;
        end
      end
      PHC_REPORT: begin
        if (cls == KIND_RREPORT) begin
          set_phase(PHC_ROGERS, KIND_RR73, MaxRetries);
          return 1'b1;
        end
        if (cls == KIND_RR73 || cls == KIND_73) begin
          set_phase(PHC_SIGNOFF, KIND_73, NO_RETRY);
          return 1'b1;
        end
      end
      PHC_ROGER_REPORT: begin
        if (cls == KIND_RR73 || cls == KIND_73) begin
          set_phase(PHC_SIGNOFF, KIND_73, NO_RETRY);
          return 1'b1;
        end
      end
      PHC_ROGERS: begin
        if (cls == KIND_RR73 || cls == KIND_73) set_phase(PHC_IDLE, KIND_NONE, NO_RETRY);
      end
      PHC_SIGNOFF: begin
        if (cls != KIND_RR73) set_phase(PHC_IDLE, KIND_NONE, NO_RETRY);
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Slot tick: repeat the phase's message, or give up once the cap is used
  function automatic void slot_tick();
    kind_e again;
    if (seq_pending == KIND_NONE || seq_phase == PHC_IDLE) return;
    case (seq_phase)
      PHC_REPLYING:     again = KIND_GRID;
      PHC_REPORT:       again = KIND_REPORT;
      PHC_ROGER_REPORT: again = KIND_RREPORT;
      PHC_ROGERS:       again = KIND_RR73;
      PHC_SIGNOFF:      again = KIND_73;
      default:          return;
    endcase
    if (seq_retries < seq_cap) begin
      seq_pending = again;
      seq_retries = seq_retries + 3'd1;
    end else if (seq_phase == PHC_ROGERS || seq_phase == PHC_SIGNOFF) begin
      seq_phase   = PHC_IDLE;
      seq_pending = KIND_NONE;
      seq_logged  = 1'b0;
    end else begin
      seq_phase   = PHC_SIGNOFF;
      seq_pending = KIND_73;
    end
  endfunction

  function automatic result_t advance_contact(item_t it);
    result_t res;
    logic    wanted;
    logic    log_req;
    kind_e   kind_out;
    wanted   = 1'b0;
    log_req  = 1'b0;
    kind_out = seq_pending;
    case (it.op)
      OP_START_CQ: set_phase(PHC_CALLING, KIND_CQ, NO_RETRY);
      OP_START_REPLY: begin
        seq_partner = it.from_call;
        set_phase(PHC_REPLYING, KIND_GRID, MaxRetries);
      end
      OP_DECODE: wanted = take_decode(it);
      OP_FETCH: begin
        if (seq_pending != KIND_NONE) begin
          wanted = 1'b1;
          if ((seq_pending == KIND_RR73 || seq_pending == KIND_73) && !seq_logged) begin
            log_req    = 1'b1;
            seq_logged = 1'b1;
          end
          // single-shot message, or retries used up: hand out and clear
          if (seq_cap == NO_RETRY || seq_retries >= seq_cap) begin
            if (seq_cap != NO_RETRY) seq_phase = PHC_SIGNOFF;
            seq_pending = KIND_NONE;
            seq_logged  = 1'b0;
          end
        end
      end
      OP_TICK: slot_tick();
      default: ;
    endcase
    if (it.op != OP_FETCH) kind_out = seq_pending;
    res.tx_wanted      = wanted;
    res.tx_kind        = kind_out;
    res.partner_call   = seq_partner;
    res.sent_report    = seq_rpt_send;
    res.partner_report = seq_rpt_heard;
    res.log_request    = log_req;
    res.phase_now      = seq_phase;
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [6:0] rand_report();
    int unsigned r;
    logic [31:0] v;
    r = $urandom_range(0, 9);
    v = $urandom();
    if (r == 0) return 7'h40;
    if (r == 1) return 7'h3F;
    return v[6:0];
  endfunction

  function automatic logic [27:0] rand_call();
    logic [31:0] v;
    v = $urandom();
    return v[27:0];
  endfunction

  function automatic void queue_event(logic [2:0] op, logic [27:0] to, logic [27:0] from,
                                      logic [6:0] snr, logic [6:0] rpt, logic grid,
                                      logic [31:0] txt);
    item_t ev;
    ev.op           = op;
    ev.to_call      = to;
    ev.from_call    = from;
    ev.heard_snr    = snr;
    ev.their_report = rpt;
    ev.is_grid      = grid;
    ev.third_field  = txt;
    tx_event_queue.push_back(ev);
  endfunction

  // One random step of a contact with the given partner, mostly well formed
  function automatic item_t rand_event(logic [27:0] mate);
    item_t       ev;
    int unsigned r;
    logic [31:0] tail;
    tail            = $urandom();
    ev.op           = OP_DECODE;
    ev.to_call      = station_call;
    ev.from_call    = mate;
    ev.heard_snr    = rand_report();
    ev.their_report = rand_report();
    ev.is_grid      = 1'b0;
    ev.third_field  = tail;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      ev.op = OP_START_CQ;
    end else if (r < 5) begin
      ev.op        = OP_START_REPLY;
      ev.from_call = rand_call();
    end else if (r < 9) begin
      ev.op      = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      ev.is_grid = 1'($urandom_range(0, 1));
    end else if (r < 30) begin
      ev.op = OP_FETCH;
    end else if (r < 50) begin
      ev.op = OP_TICK;
    end else begin
      // noise: wrong addressee or a stranger
      if ($urandom_range(0, 9) == 0) ev.to_call = rand_call();
      if ($urandom_range(0, 7) == 0) ev.from_call = rand_call();
      r = $urandom_range(0, 99);
      if (r < 20) ev.is_grid = 1'b1;
      else if (r < 40) ev.third_field = {($urandom_range(0, 1) ? CH_MINUS : CH_PLUS), tail[23:0]};
      else if (r < 60) ev.third_field = {CH_R, tail[23:0]};
      else if (r < 66) ev.third_field = TXT_RR73;
      else if (r < 72) ev.third_field = {PFX_RRR, tail[7:0]};
      else if (r < 85) ev.third_field = {PFX_73, tail[15:0]};
    end
    return ev;
  endfunction

  // Contacts: a start item then a run of random steps with one partner
  task automatic queue_contacts(int unsigned n);
    int unsigned  count;
    int unsigned  len;
    logic [27:0]  mate;
    count = 0;
    while (count < n) begin
      mate = rand_call();
      if ($urandom_range(0, 1) == 0)
        queue_event(OP_START_CQ, rand_call(), rand_call(), rand_report(), rand_report(),
                    1'b0, $urandom());
      else
        queue_event(OP_START_REPLY, rand_call(), mate, rand_report(), rand_report(),
                    1'b0, $urandom());
      len = $urandom_range(4, 16);
      repeat (len) tx_event_queue.push_back(rand_event(mate));
      count += len + 1;
    end
  endtask

  task automatic write_station_call(logic [27:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    station_call = v;
  endtask

  // Wait until every item is sent and every result has come back
  task automatic drain();
    while (tx_event_queue.size() != 0 || s_axis_tvalid || predicted_status.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- sender

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      src_gap       <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predicted_status.push_back(advance_contact(offered));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap != 0) begin
          src_gap       <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (tx_event_queue.size() != 0) begin
          offered = tx_event_queue.pop_front();
          s_axis_tdata  <= {2'b00, offered.third_field, offered.their_report,
                            offered.heard_snr, offered.from_call, offered.to_call};
          s_axis_tuser  <= {offered.is_grid, offered.op};
          s_axis_tvalid <= 1'b1;
          src_gap       <= src_gaps_on ? pick_gap() : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  // Ready with random stalls; a requested hold-off takes precedence
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_gap      <= 0;
      hold_left     <= 0;
      holds_done    <= 0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      holds_done    <= holds_asked;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (sink_gap != 0) begin
      m_axis_tready <= 1'b0;
      sink_gap      <= sink_gap - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (sink_gaps_on && $urandom_range(0, 3) == 0) sink_gap <= pick_gap();
    end
  end

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (predicted_status.size() == 0) begin
        $error("result item arrived with nothing outstanding");
        mismatches++;
      end else begin
        status_due = predicted_status.pop_front();
        compare_field("tx_wanted", {31'd0, status_due.tx_wanted}, {31'd0, m_axis_tdata[0]});
        compare_field("tx_kind", {29'd0, status_due.tx_kind}, {29'd0, m_axis_tuser});
        compare_field("partner_call", {4'd0, status_due.partner_call},
                      {4'd0, m_axis_tdata[28:1]});
        compare_field("sent_report", {25'd0, status_due.sent_report},
                      {25'd0, m_axis_tdata[35:29]});
        compare_field("partner_report", {25'd0, status_due.partner_report},
                      {25'd0, m_axis_tdata[42:36]});
        compare_field("log_request", {31'd0, status_due.log_request},
                      {31'd0, m_axis_tdata[43]});
        compare_field("phase_now", {29'd0, status_due.phase_now}, {29'd0, m_axis_tdata[46:44]});
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- test sequence

  initial begin
    logic [27:0] mate;
    logic [27:0] stranger;
    logic [27:0] call_now;
    mate     = 28'h1234567;
    stranger = 28'h7654321;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: ignored codes, idle behaviour, CQ, give-up on fetch, sign-off paths
    write_station_call(28'h0ABCDEF);
    @(negedge clk_i);
    queue_event(OP_UNUSED_LO, 28'hFFFFFFF, 28'hFFFFFFF, 7'h3F, 7'h3F, 1'b1, 32'hFFFF_FFFF);
    queue_event(OP_UNUSED_HI, '0, '0, '0, '0, 1'b0, '0);
    queue_event(OP_TICK, '0, '0, '0, '0, 1'b0, '0);
    queue_event(OP_FETCH, '0, '0, '0, '0, 1'b0, '0);
    queue_event(OP_DECODE, station_call, mate, 7'h3F, 7'h3F, 1'b1, TXT_GRID);
    queue_event(OP_START_CQ, '0, '0, '0, '0, 1'b0, '0);
    queue_event(OP_FETCH, '0, '0, '0, '0, 1'b0, '0);
    queue_event(OP_FETCH, '0, '0, '0, '0, 1'b0, '0);
    queue_event(OP_TICK, '0, '0, '0, '0, 1'b0, '0);
    queue_event(OP_DECODE, station_call, mate, 7'h40, 7'h40, 1'b0, TXT_RPT);
    queue_event(OP_DECODE, station_call, stranger, 7'h05, 7'h05, 1'b0, TXT_RR73);
    queue_event(OP_DECODE, ~station_call, mate, 7'h05, 7'h05, 1'b0, TXT_RR73);
    queue_event(OP_FETCH, '0, '0, '0, '0, 1'b0, '0);
    repeat (5) queue_event(OP_TICK, '0, '0, '0, '0, 1'b0, '0);
    queue_event(OP_FETCH, '0, '0, '0, '0, 1'b0, '0);
    queue_event(OP_START_REPLY, '0, mate, '0, '0, 1'b0, '0);
    queue_event(OP_DECODE, station_call, mate, 7'h7F, 7'h01, 1'b0, TXT_RRR);
    queue_event(OP_FETCH, '0, '0, '0, '0, 1'b0, '0);
    queue_event(OP_START_REPLY, '0, mate, '0, '0, 1'b0, '0);
    queue_event(OP_DECODE, station_call, mate, 7'h10, 7'h70, 1'b0, TXT_RRPT);
    queue_event(OP_DECODE, station_call, mate, 7'h20, 7'h30, 1'b0, TXT_RR73);
    queue_event(OP_START_REPLY, '0, mate, '0, '0, 1'b0, '0);
    queue_event(OP_DECODE, station_call, mate, 7'h01, 7'h02, 1'b0, TXT_73);
    queue_event(OP_FETCH, '0, '0, '0, '0, 1'b0, '0);
    drain();

    // Random contacts under several callsigns and handshake patterns
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) call_now = 28'hFFFFFFF;
      else if (p == 1) call_now = '0;
      else call_now = rand_call();
      write_station_call(call_now);
      @(negedge clk_i);
      src_gaps_on  = (p != 1 && p != 2);
      sink_gaps_on = (p != 2 && p != 3);
      queue_contacts(PHASE_ITEMS);
      // long receiver hold-off while the sender keeps offering
      if (p == 2) holds_asked++;
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
